// ===== sv/sbf_pkg.sv =====
// Shared constants, types and helpers for the boundary fill unit.
package sbf_pkg;

	localparam int FB_WIDTH    = 256;
	localparam int FB_HEIGHT   = 256;
	localparam int STACK_DEPTH = 65536;

	localparam int FB_DEPTH = FB_WIDTH * FB_HEIGHT;
	localparam int XC_W     = $clog2(FB_WIDTH);
	localparam int YC_W     = $clog2(FB_HEIGHT);
	localparam int CRD_W    = (XC_W > YC_W) ? XC_W : YC_W;
	localparam int ADDR_W   = $clog2(FB_DEPTH);
	localparam int SP_W     = $clog2(STACK_DEPTH + 1);
	localparam int SI_W     = $clog2(STACK_DEPTH);
	localparam int PIX_W    = 24;
	localparam int CNT_W    = 17;

	localparam logic [1:0] CMD_WRITE = 2'd0;
	localparam logic [1:0] CMD_READ  = 2'd1;
	localparam logic [1:0] CMD_FILL  = 2'd2;

	// neighbour order: right, left, down, up
	localparam logic [1:0] DIR_XP = 2'd0;
	localparam logic [1:0] DIR_XM = 2'd1;
	localparam logic [1:0] DIR_YP = 2'd2;
	localparam logic [1:0] DIR_YM = 2'd3;

	localparam logic REG_FILL     = 1'b0;
	localparam logic REG_BOUNDARY = 1'b1;

	localparam logic [PIX_W-1:0] FILL_RESET     = 24'hFFFF00;
	localparam logic [PIX_W-1:0] BOUNDARY_RESET = 24'h000000;

	typedef logic [PIX_W-1:0]  pix_t;
	typedef logic [CNT_W-1:0]  cnt_t;
	typedef logic [ADDR_W-1:0] addr_t;
	typedef logic [SP_W-1:0]   sp_t;
	typedef logic [XC_W-1:0]   xc_t;
	typedef logic [YC_W-1:0]   yc_t;
	typedef logic [CRD_W:0]    crd_ext_t;

	typedef struct packed {
		logic oob;
		yc_t  y;
		xc_t  x;
	} coord_t;

	typedef struct packed {
		logic [1:0] cmd;
		logic [7:0] pos_x;
		logic [7:0] pos_y;
		pix_t       pixel_value;
	} in_item_t;

	typedef struct packed {
		pix_t read_value;
		cnt_t painted_count;
		logic stack_overflow;
	} out_item_t;

	typedef struct packed {
		logic  rd_en;
		logic  wr_en;
		addr_t addr;
		pix_t  wdata;
	} fb_req_t;

	typedef struct packed {
		logic   push;
		logic   pop;
		coord_t wdata;
	} stk_req_t;

	typedef struct packed {
		logic empty;
		logic full;
	} stk_sts_t;

	function automatic addr_t pix_addr(input xc_t x, input yc_t y);
		return addr_t'(addr_t'(y) * addr_t'(FB_WIDTH) + addr_t'(x));
	endfunction

endpackage

// ===== sv/stack_boundary_fill_unit.sv =====
// Top level: request channels, APB registers and the fill sequencer.
//
// Frame buffer of 256 x 256 packed 24-bit RGB pixels with a 4-connected boundary
// fill. After reset the block sweeps the frame to zero, one pixel per cycle, and
// takes no request until the sweep ends; register writes are taken throughout.
// A write request (and an unused command) goes straight to the output register;
// a read passes through the registered frame port first. A fill pops coordinates
// from the stack until it is empty: one off the frame is dropped, one whose pixel
// holds the boundary or fill color is skipped, and one that is painted gets the
// fill color, and the one neighbour step unit then pushes its four neighbours,
// one per cycle. A result waits in an output register; the next request is taken
// while it is handed over.
module stack_boundary_fill_unit (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  sbf_pkg::in_item_t   in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output sbf_pkg::out_item_t  out_data,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [2:0]          paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready
);

	localparam logic [2:0] ST_CLEAR = 3'd0;
	localparam logic [2:0] ST_IDLE  = 3'd1;
	localparam logic [2:0] ST_READ  = 3'd2;
	localparam logic [2:0] ST_POP   = 3'd3;
	localparam logic [2:0] ST_LOAD  = 3'd4;
	localparam logic [2:0] ST_CHECK = 3'd5;
	localparam logic [2:0] ST_PUSH  = 3'd6;

	logic [2:0]         state_q;
	sbf_pkg::pix_t      fill_q;
	sbf_pkg::pix_t      bnd_q;
	logic               out_valid_q;
	sbf_pkg::out_item_t out_data_q;
	logic               rd_hit_q;
	sbf_pkg::cnt_t      count_q;
	logic               ovf_q;
	sbf_pkg::xc_t       cur_x_q;
	sbf_pkg::yc_t       cur_y_q;
	sbf_pkg::addr_t     cur_addr_q;
	logic [1:0]         dir_q;

	sbf_pkg::fb_req_t   fb_req;
	sbf_pkg::pix_t      fb_rdata;
	logic               fb_busy;
	sbf_pkg::stk_req_t  stk_req;
	sbf_pkg::coord_t    stk_rdata;
	sbf_pkg::stk_sts_t  stk_sts;
	sbf_pkg::coord_t    nbr;

	logic               in_fire;
	logic               in_hit;
	sbf_pkg::xc_t       in_x;
	sbf_pkg::yc_t       in_y;
	sbf_pkg::addr_t     in_addr;
	logic               paint;
	logic               res_load;
	logic               cfg_wr;

	assign in_ready = (state_q == ST_IDLE) && (!out_valid_q || out_ready);
	assign in_fire  = in_valid && in_ready;
	assign in_hit   = (32'(in_data.pos_x) < sbf_pkg::FB_WIDTH)
	               && (32'(in_data.pos_y) < sbf_pkg::FB_HEIGHT);
	assign in_x     = sbf_pkg::xc_t'(in_data.pos_x);
	assign in_y     = sbf_pkg::yc_t'(in_data.pos_y);
	assign in_addr  = sbf_pkg::pix_addr(in_x, in_y);
	assign paint    = !((fb_rdata == bnd_q) || (fb_rdata == fill_q));

	sbf_frame_store u_frame (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (fb_req),
		.rdata  (fb_rdata),
		.busy   (fb_busy)
	);

	sbf_coord_stack u_stack (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (stk_req),
		.rdata  (stk_rdata),
		.sts    (stk_sts)
	);

	sbf_nbr_unit u_nbr (
		.cur_x (cur_x_q),
		.cur_y (cur_y_q),
		.dir   (dir_q),
		.nbr   (nbr)
	);

	// memory requests
	always_comb begin
		fb_req  = '0;
		stk_req = '0;
		unique case (state_q)
			ST_IDLE: begin
				fb_req.addr  = in_addr;
				fb_req.wdata = in_data.pixel_value;
				if (in_fire && in_hit) begin
					fb_req.wr_en = (in_data.cmd == sbf_pkg::CMD_WRITE);
					fb_req.rd_en = (in_data.cmd == sbf_pkg::CMD_READ);
				end
				stk_req.push      = in_fire && (in_data.cmd == sbf_pkg::CMD_FILL);
				stk_req.wdata.oob = !in_hit;
				stk_req.wdata.x   = in_x;
				stk_req.wdata.y   = in_y;
			end
			ST_POP: begin
				stk_req.pop = !stk_sts.empty;
			end
			ST_LOAD: begin
				fb_req.rd_en = !stk_rdata.oob;
				fb_req.addr  = sbf_pkg::pix_addr(stk_rdata.x, stk_rdata.y);
			end
			ST_CHECK: begin
				fb_req.wr_en = paint;
				fb_req.addr  = cur_addr_q;
				fb_req.wdata = fill_q;
			end
			ST_PUSH: begin
				stk_req.push  = 1'b1;
				stk_req.wdata = nbr;
			end
			default: begin
			end
		endcase
	end

	// a result enters the output register
	always_comb begin
		res_load = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				res_load = in_fire && (in_data.cmd != sbf_pkg::CMD_READ)
				        && (in_data.cmd != sbf_pkg::CMD_FILL);
			end
			ST_READ: begin
				res_load = 1'b1;
			end
			ST_POP: begin
				res_load = stk_sts.empty;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			rd_hit_q    <= 1'b0;
			count_q     <= '0;
			ovf_q       <= 1'b0;
			dir_q       <= sbf_pkg::DIR_XP;
		end else begin
			unique case (state_q)
				ST_CLEAR: begin
					if (!fb_busy) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (in_fire) begin
						case (in_data.cmd)
							sbf_pkg::CMD_READ: begin
								rd_hit_q <= in_hit;
								state_q  <= ST_READ;
							end
							sbf_pkg::CMD_FILL: begin
								count_q <= '0;
								ovf_q   <= 1'b0;
								state_q <= ST_POP;
							end
							default: begin
								out_data_q  <= '0;
							end
						endcase
					end
				end
				ST_READ: begin
					out_data_q.read_value     <= rd_hit_q ? fb_rdata : '0;
					out_data_q.painted_count  <= '0;
					out_data_q.stack_overflow <= 1'b0;
					state_q <= ST_IDLE;
				end
				ST_POP: begin
					if (stk_sts.empty) begin
						out_data_q.read_value     <= '0;
						out_data_q.painted_count  <= count_q;
						out_data_q.stack_overflow <= ovf_q;
						state_q <= ST_IDLE;
					end else begin
						state_q <= ST_LOAD;
					end
				end
				ST_LOAD: begin
					cur_x_q    <= stk_rdata.x;
					cur_y_q    <= stk_rdata.y;
					cur_addr_q <= sbf_pkg::pix_addr(stk_rdata.x, stk_rdata.y);
					state_q    <= stk_rdata.oob ? ST_POP : ST_CHECK;
				end
				ST_CHECK: begin
					if (paint) begin
						if (count_q != '1) begin
							count_q <= count_q + 1'b1;
						end
						dir_q   <= sbf_pkg::DIR_XP;
						state_q <= ST_PUSH;
					end else begin
						state_q <= ST_POP;
					end
				end
				ST_PUSH: begin
					// drop the push when full and flag it
					if (stk_sts.full) begin
						ovf_q <= 1'b1;
					end
					dir_q <= dir_q + 1'b1;
					if (dir_q == sbf_pkg::DIR_YM) begin
						state_q <= ST_POP;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// configuration registers
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= sbf_pkg::FILL_RESET;
			bnd_q  <= sbf_pkg::BOUNDARY_RESET;
		end else if (cfg_wr) begin
			unique case (paddr[2])
				sbf_pkg::REG_FILL:     fill_q <= pwdata[sbf_pkg::PIX_W-1:0];
				sbf_pkg::REG_BOUNDARY: bnd_q  <= pwdata[sbf_pkg::PIX_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			sbf_pkg::REG_FILL:     prdata = {8'd0, fill_q};
			sbf_pkg::REG_BOUNDARY: prdata = {8'd0, bnd_q};
			default:               prdata = '0;
		endcase
	end

	assign pready    = 1'b1;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

// ===== sv/sbf_frame_store.sv =====
// Frame buffer memory with its post-reset clearing sweep.
module sbf_frame_store (
	input  logic             clk,
	input  logic             arst_n,
	input  sbf_pkg::fb_req_t req,
	output sbf_pkg::pix_t    rdata,
	output logic             busy
);

	sbf_pkg::pix_t  mem [sbf_pkg::FB_DEPTH];
	sbf_pkg::pix_t  rdata_q;
	sbf_pkg::addr_t clr_addr_q;
	logic           clr_busy_q;
	logic           we;
	sbf_pkg::addr_t wa;
	sbf_pkg::pix_t  wd;

	always_comb begin
		we = clr_busy_q | req.wr_en;
		wa = clr_busy_q ? clr_addr_q : req.addr;
		wd = clr_busy_q ? '0 : req.wdata;
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
		if (req.rd_en) begin
			rdata_q <= mem[req.addr];
		end
	end

	// sweep every pixel to zero once after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_busy_q) begin
			if (clr_addr_q == sbf_pkg::addr_t'(sbf_pkg::FB_DEPTH - 1)) begin
				clr_busy_q <= 1'b0;
			end
			clr_addr_q <= clr_addr_q + 1'b1;
		end
	end

	assign rdata = rdata_q;
	assign busy  = clr_busy_q;

endmodule

// ===== sv/sbf_coord_stack.sv =====
// Coordinate stack memory and its pointer; full pushes are dropped.
module sbf_coord_stack (
	input  logic              clk,
	input  logic              arst_n,
	input  sbf_pkg::stk_req_t req,
	output sbf_pkg::coord_t   rdata,
	output sbf_pkg::stk_sts_t sts
);

	sbf_pkg::coord_t mem [sbf_pkg::STACK_DEPTH];
	sbf_pkg::coord_t rdata_q;
	sbf_pkg::sp_t    sp_q;
	sbf_pkg::sp_t    sp_m1;
	logic            full;
	logic            empty;

	assign sp_m1 = sp_q - 1'b1;
	assign full  = (sp_q == sbf_pkg::sp_t'(sbf_pkg::STACK_DEPTH));
	assign empty = (sp_q == '0);

	always_ff @(posedge clk) begin
		if (req.push && !full) begin
			mem[sp_q[sbf_pkg::SI_W-1:0]] <= req.wdata;
		end
		if (req.pop) begin
			rdata_q <= mem[sp_m1[sbf_pkg::SI_W-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sp_q <= '0;
		end else if (req.push && !full) begin
			sp_q <= sp_q + 1'b1;
		end else if (req.pop && !empty) begin
			sp_q <= sp_m1;
		end
	end

	assign rdata     = rdata_q;
	assign sts.empty = empty;
	assign sts.full  = full;

endmodule

// ===== sv/sbf_nbr_unit.sv =====
// Shared neighbour step unit: one adder and bound compare, reused for all four directions.
module sbf_nbr_unit (
	input  sbf_pkg::xc_t    cur_x,
	input  sbf_pkg::yc_t    cur_y,
	input  logic [1:0]      dir,
	output sbf_pkg::coord_t nbr
);

	logic              on_y;
	logic              dec;
	sbf_pkg::crd_ext_t v_ext;
	sbf_pkg::crd_ext_t lim;
	sbf_pkg::crd_ext_t sum;

	always_comb begin
		unique case (dir)
			sbf_pkg::DIR_XP: begin
				on_y = 1'b0;
				dec  = 1'b0;
			end
			sbf_pkg::DIR_XM: begin
				on_y = 1'b0;
				dec  = 1'b1;
			end
			sbf_pkg::DIR_YP: begin
				on_y = 1'b1;
				dec  = 1'b0;
			end
			default: begin
				on_y = 1'b1;
				dec  = 1'b1;
			end
		endcase
	end

	always_comb begin
		v_ext = on_y ? sbf_pkg::crd_ext_t'(cur_y) : sbf_pkg::crd_ext_t'(cur_x);
		lim   = on_y ? sbf_pkg::crd_ext_t'(sbf_pkg::FB_HEIGHT)
		             : sbf_pkg::crd_ext_t'(sbf_pkg::FB_WIDTH);
		sum   = v_ext + (dec ? '1 : sbf_pkg::crd_ext_t'(1));
		// off the frame: stepping left/up from zero, or right/down onto the limit
		nbr.oob = dec ? (v_ext == '0) : (sum == lim);
		nbr.x   = on_y ? cur_x : sum[sbf_pkg::XC_W-1:0];
		nbr.y   = on_y ? sum[sbf_pkg::YC_W-1:0] : cur_y;
	end

endmodule

// ===== tb/sv/stack_boundary_fill_unit_test.sv =====
// Self-checking testbench for the boundary fill unit: request driver, result monitor, fill predictor.
module stack_boundary_fill_unit_test;

	localparam logic [1:0] CMD_UNUSED = 2'd3;
	localparam int COUNT_SAT     = (1 << sbf_pkg::CNT_W) - 1;
	localparam int CYCLE_LIMIT   = 8000000;
	localparam int SETTLE_CYCLES = 10;
	localparam int END_WAIT      = 20;
	localparam int LONG_HOLD     = 400;
	localparam int PHASE_ITEMS   = 300;
	localparam int DEEP_EDGE     = 128;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	sbf_pkg::in_item_t  in_data = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	sbf_pkg::out_item_t out_data;
	logic               psel = 1'b0;
	logic               penable = 1'b0;
	logic               pwrite = 1'b0;
	logic [2:0]         paddr = '0;
	logic [31:0]        pwdata = '0;
	logic [31:0]        prdata;
	logic               pready;

	stack_boundary_fill_unit uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// predicted block state
	sbf_pkg::pix_t frame_img [sbf_pkg::FB_DEPTH];
	int            stk_x [sbf_pkg::STACK_DEPTH];
	int            stk_y [sbf_pkg::STACK_DEPTH];
	int            stk_top;
	bit            stk_dropped;
	sbf_pkg::pix_t fill_reg = sbf_pkg::FILL_RESET;
	sbf_pkg::pix_t bound_reg = sbf_pkg::BOUNDARY_RESET;

	sbf_pkg::in_item_t  request_queue [$];
	sbf_pkg::out_item_t expected_results [$];
	sbf_pkg::out_item_t res_now;
	sbf_pkg::out_item_t want;

	int     queued_total = 0;
	int     accepted_total = 0;
	int     phase_items = 0;
	int     send_gap_pct = 0;
	int     recv_stall_pct = 0;
	int     mismatch_count = 0;
	int     cycle_count = 0;
	int     reg_writes = 0;
	int     overflow_fills = 0;
	longint painted_total = 0;
	int     cmd_seen [4] = '{0, 0, 0, 0};
	bit     hold_request = 1'b0;
	logic   out_hold = 1'b0;

	function automatic bit on_frame(input int x, input int y);
		return x >= 0 && y >= 0 && x < sbf_pkg::FB_WIDTH && y < sbf_pkg::FB_HEIGHT;
	endfunction

	function automatic void push_coord(input int x, input int y);
		if (stk_top >= sbf_pkg::STACK_DEPTH) begin
			stk_dropped = 1'b1;
		end else begin
			stk_x[stk_top] = x;
			stk_y[stk_top] = y;
			stk_top++;
		end
	endfunction

	function automatic sbf_pkg::out_item_t predict_result(input sbf_pkg::in_item_t req);
		sbf_pkg::out_item_t res;
		int x;
		int y;
		int idx;
		int painted;
		res = '0;
		x = int'(req.pos_x);
		y = int'(req.pos_y);
		case (req.cmd)
		sbf_pkg::CMD_WRITE: begin
			if (on_frame(x, y))
				frame_img[y * sbf_pkg::FB_WIDTH + x] = req.pixel_value;
		end
		sbf_pkg::CMD_READ: begin
			if (on_frame(x, y))
				res.read_value = frame_img[y * sbf_pkg::FB_WIDTH + x];
		end
		sbf_pkg::CMD_FILL: begin
			painted = 0;
			stk_top = 0;
			stk_dropped = 1'b0;
			push_coord(x, y);
			while (stk_top > 0) begin
				stk_top--;
				x = stk_x[stk_top];
				y = stk_y[stk_top];
				if (on_frame(x, y)) begin
					idx = y * sbf_pkg::FB_WIDTH + x;
					if (frame_img[idx] != bound_reg && frame_img[idx] != fill_reg) begin
						frame_img[idx] = fill_reg;
						if (painted < COUNT_SAT)
							painted++;
						push_coord(x + 1, y);
						push_coord(x - 1, y);
						push_coord(x, y + 1);
						push_coord(x, y - 1);
					end
				end
			end
			res.painted_count = sbf_pkg::cnt_t'(painted);
			res.stack_overflow = stk_dropped;
		end
		default: ;
		endcase
		return res;
	endfunction

	// request driver
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready) begin
				res_now = predict_result(in_data);
				expected_results.push_back(res_now);
				accepted_total++;
				cmd_seen[in_data.cmd]++;
				painted_total += res_now.painted_count;
				overflow_fills += res_now.stack_overflow;
			end
			if (!in_valid || in_ready) begin
				if (request_queue.size() != 0 && $urandom_range(0, 99) >= send_gap_pct) begin
					in_valid <= 1'b1;
					in_data <= request_queue.pop_front();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// result monitor
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (expected_results.size() == 0) begin
					$error("result with no request outstanding: %p", out_data);
					mismatch_count++;
				end else begin
					want = expected_results.pop_front();
					if (out_data.read_value !== want.read_value) begin
						$error("read_value: expected %06h, got %06h",
							want.read_value, out_data.read_value);
						mismatch_count++;
					end
					if (out_data.painted_count !== want.painted_count) begin
						$error("painted_count: expected %0d, got %0d",
							want.painted_count, out_data.painted_count);
						mismatch_count++;
					end
					if (out_data.stack_overflow !== want.stack_overflow) begin
						$error("stack_overflow: expected %0b, got %0b",
							want.stack_overflow, out_data.stack_overflow);
						mismatch_count++;
					end
				end
			end
			out_ready <= !out_hold && ($urandom_range(0, 99) >= recv_stall_pct);
		end
	end

	// long hold-off on the result port, counted here
	always begin
		wait (hold_request);
		@(posedge clk);
		out_hold <= 1'b1;
		repeat (LONG_HOLD) @(posedge clk);
		out_hold <= 1'b0;
		hold_request = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("FAIL stack_boundary_fill_unit");
			$finish;
		end
	end

	function automatic void add_request(input logic [1:0] cmd, input int x, input int y,
			input sbf_pkg::pix_t value);
		sbf_pkg::in_item_t req;
		req.cmd = cmd;
		req.pos_x = 8'(x);
		req.pos_y = 8'(y);
		req.pixel_value = value;
		request_queue.push_back(req);
		queued_total++;
		if (cmd != CMD_UNUSED)
			phase_items++;
	endfunction

	function automatic sbf_pkg::pix_t blob_color();
		case ($urandom_range(0, 9))
		0: return '0;
		1: return fill_reg;
		2: return '1;
		default: return sbf_pkg::pix_t'($urandom);
		endcase
	endfunction

	// write a small patch of colors, flood it from inside, read back pixels in and just beyond it
	function automatic void add_blob();
		int bx;
		int by;
		int w;
		int h;
		int i;
		int j;
		bx = $urandom_range(0, sbf_pkg::FB_WIDTH - 1);
		by = $urandom_range(0, sbf_pkg::FB_HEIGHT - 1);
		w = $urandom_range(1, 6);
		h = $urandom_range(1, 6);
		for (j = 0; j < h; j++)
			for (i = 0; i < w; i++)
				if (bx + i < sbf_pkg::FB_WIDTH && by + j < sbf_pkg::FB_HEIGHT)
					add_request(sbf_pkg::CMD_WRITE, bx + i, by + j, blob_color());
		add_request(sbf_pkg::CMD_FILL, bx + $urandom_range(0, w - 1),
			by + $urandom_range(0, h - 1), sbf_pkg::pix_t'($urandom));
		for (i = $urandom_range(1, 3); i > 0; i--)
			add_request(sbf_pkg::CMD_READ, bx + $urandom_range(0, w),
				by + $urandom_range(0, h), sbf_pkg::pix_t'($urandom));
	endfunction

	task automatic drain();
		do @(posedge clk); while (accepted_total != queued_total || expected_results.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic reg_sel, input sbf_pkg::pix_t value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {reg_sel, 2'b00};
		pwdata <= {8'h00, value};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (reg_sel == sbf_pkg::REG_FILL)
			fill_reg = value;
		else
			bound_reg = value;
		reg_writes++;
	endtask

	task automatic run_phase(input int gap_pct, input int stall_pct);
		send_gap_pct = gap_pct;
		recv_stall_pct = stall_pct;
		phase_items = 0;
		while (phase_items < PHASE_ITEMS) begin
			if ($urandom_range(0, 4) == 0)
				add_request(2'($urandom_range(0, 3)), $urandom_range(0, sbf_pkg::FB_WIDTH - 1),
					$urandom_range(0, sbf_pkg::FB_HEIGHT - 1), sbf_pkg::pix_t'($urandom));
			else
				add_blob();
		end
		drain();
	endtask

	initial begin
		int row;
		foreach (frame_img[i])
			frame_img[i] = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// directed: corners, unused command, lone pixels, seeds on stop colors
		add_request(sbf_pkg::CMD_READ, 0, 0, '1);
		add_request(sbf_pkg::CMD_READ, 255, 255, '0);
		add_request(sbf_pkg::CMD_WRITE, 0, 0, '1);
		add_request(sbf_pkg::CMD_WRITE, 255, 255, 24'h000001);
		add_request(sbf_pkg::CMD_WRITE, 255, 0, sbf_pkg::FILL_RESET);
		add_request(sbf_pkg::CMD_WRITE, 0, 255, 24'h800000);
		add_request(CMD_UNUSED, 255, 255, '1);
		add_request(sbf_pkg::CMD_READ, 0, 0, '0);
		add_request(sbf_pkg::CMD_READ, 255, 255, '0);
		add_request(sbf_pkg::CMD_READ, 255, 0, '0);
		add_request(sbf_pkg::CMD_FILL, 0, 0, '0);
		add_request(sbf_pkg::CMD_FILL, 255, 0, '1);
		add_request(sbf_pkg::CMD_FILL, 10, 10, '0);
		add_request(sbf_pkg::CMD_FILL, 255, 255, '0);
		add_request(sbf_pkg::CMD_READ, 0, 0, '1);
		add_request(sbf_pkg::CMD_WRITE, 100, 50, 24'h123456);
		add_request(sbf_pkg::CMD_WRITE, 101, 50, 24'hABCDEF);
		add_request(sbf_pkg::CMD_WRITE, 102, 50, 24'h000001);
		add_request(sbf_pkg::CMD_WRITE, 100, 51, 24'hFFFFFE);
		add_request(sbf_pkg::CMD_WRITE, 101, 51, 24'h7F7F7F);
		add_request(sbf_pkg::CMD_WRITE, 102, 51, 24'h800080);
		add_request(sbf_pkg::CMD_FILL, 101, 50, '1);
		add_request(sbf_pkg::CMD_READ, 102, 51, '0);
		drain();

		write_reg(sbf_pkg::REG_FILL, '1);
		write_reg(sbf_pkg::REG_BOUNDARY, '0);
		// back up the block while requests keep coming
		hold_request = 1'b1;
		run_phase(0, 0);

		// fill color equal to the boundary color
		write_reg(sbf_pkg::REG_FILL, '0);
		run_phase(49, 0);

		write_reg(sbf_pkg::REG_FILL, sbf_pkg::pix_t'($urandom));
		run_phase(0, 49);

		write_reg(sbf_pkg::REG_FILL, sbf_pkg::pix_t'($urandom));
		run_phase(30, 30);

		// wall off the left half and fill it deep enough to overrun the stack
		write_reg(sbf_pkg::REG_BOUNDARY, '1);
		write_reg(sbf_pkg::REG_FILL, 24'h00FF00);
		send_gap_pct = 0;
		recv_stall_pct = 0;
		for (row = 0; row < sbf_pkg::FB_HEIGHT; row++)
			add_request(sbf_pkg::CMD_WRITE, DEEP_EDGE, row, '1);
		add_request(sbf_pkg::CMD_WRITE, DEEP_EDGE - 1, sbf_pkg::FB_HEIGHT - 1, 24'h5A5A5A);
		add_request(sbf_pkg::CMD_FILL, DEEP_EDGE - 1, sbf_pkg::FB_HEIGHT - 1,
			sbf_pkg::pix_t'($urandom));
		add_request(sbf_pkg::CMD_READ, 0, 0, sbf_pkg::pix_t'($urandom));
		drain();
		repeat (END_WAIT) @(posedge clk);

		$display("Ran %0d requests (%0d writes, %0d reads, %0d fills, %0d unused),",
			accepted_total, cmd_seen[sbf_pkg::CMD_WRITE], cmd_seen[sbf_pkg::CMD_READ],
			cmd_seen[sbf_pkg::CMD_FILL], cmd_seen[CMD_UNUSED]);
		$display("%0d register writes; fills painted %0d pixels, %0d overran the stack.",
			reg_writes, painted_total, overflow_fills);
		if (mismatch_count == 0)
			$display("PASS stack_boundary_fill_unit");
		else
			$display("FAIL stack_boundary_fill_unit");
		$finish;
	end

endmodule
